### hdl/siwl_pkg.sv
// Shared types and constants for the sorted interval wait lookup unit.
// Used by siwl_ctrl, siwl_dpath and the top level; depends on nothing.
package siwl_pkg;

    localparam int TIME_W            = 30;
    localparam int WAIT_W            = 31;
    localparam int MAX_INTERVALS_DEF = 1024;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef struct packed {
        func_t               func;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   end_time;
        logic [TIME_W-1:0]   point;
    } req_t;

    typedef struct packed {
        logic                     status;
        logic signed [WAIT_W-1:0] wait_span;
    } rsp_t;

    // Memory read address source
    typedef enum logic [1:0] {
        RD_MID   = 2'd0,
        RD_PREV  = 2'd1,
        RD_NEXT  = 2'd2,
        RD_SHIFT = 2'd3
    } rd_sel_t;

    // Result kind
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_FULL = 2'd1,
        RES_NONE = 2'd2,
        RES_GAP  = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     clear_count;
        logic     search_init;
        logic     search_step;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     shift_write;
        logic     ins_write;
        logic     res_set;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  lo_lt_hi;
        logic  shift_more;
        logic  lo_nonzero;
        logic  lo_lt_count;
        logic  in_prev;
        logic  out_free;
    } sts_t;

endpackage

### hdl/sorted_interval_wait_lookup_unit.sv
// Top level of the sorted interval wait lookup unit.
// Joins siwl_ctrl and siwl_dpath; depends on siwl_pkg.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one command:
//   clear the table, insert an interval [start_time, end_time), or query a
//   point. Each request gives exactly one transfer on the response channel
//   (rsp_valid, rsp_stall, rsp_data) with status and wait_span.
//   Requests are handled one at a time. req_stall is low only while the
//   controller is idle; one request is taken even while a finished response
//   still waits in the output register.
//   A request runs to its response as follows, with p search probes
//   (p at most ceil(log2(n+1)) for n stored entries):
//     clear, unused code, full-table insert: no search and no memory access
//     query: p probes, each a read of the registered-read interval memory
//            and a compare, then up to two more reads
//     insert: p probes, then a read and a write for each of the m entries
//            moved up, then the write of the new entry
//   The single read port of the memories serves both search and shifting.
//   Reset empties the table at once (entry count to zero); no clearing pass.
//   While rsp_stall is high the response is held and the unit finishes the
//   request at hand, then waits with req_stall high.
module sorted_interval_wait_lookup_unit
    import siwl_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t cmd;
    sts_t sts;

    siwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    siwl_dpath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### hdl/siwl_dpath.sv
// Datapath of the sorted interval wait lookup unit: interval memories, search
// bounds, entry count, result and output registers. Depends on siwl_pkg.
module siwl_dpath
    import siwl_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  logic rsp_stall,
    output logic rsp_valid,
    output rsp_t rsp_data,
    input  cmd_t cmd,
    output sts_t sts
);

    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int ADDR_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    logic [TIME_W-1:0] start_mem [MAX_INTERVALS];
    logic [TIME_W-1:0] end_mem   [MAX_INTERVALS];

    req_t              item_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [TIME_W-1:0] rd_start_reg;
    logic [TIME_W-1:0] rd_end_reg;
    rsp_t              res_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_start;
    logic [TIME_W-1:0] wr_end;
    logic              wr_en;
    logic [TIME_W-1:0] key;
    logic              go_right;
    logic [WAIT_W-1:0] gap;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:   rd_idx = mid;
            RD_PREV:  rd_idx = lo_reg - CNT_W'(1);
            RD_NEXT:  rd_idx = lo_reg;
            RD_SHIFT: rd_idx = j_reg - CNT_W'(1);
            default:  rd_idx = mid;
        endcase
    end
    assign rd_addr = rd_idx[ADDR_W-1:0];

    // Insert places equal starts after the stored ones; query stops before them
    assign key      = (item_reg.func == FUNC_INSERT) ? item_reg.start_time : item_reg.point;
    assign go_right = (item_reg.func == FUNC_INSERT) ? (rd_start_reg <= key)
                                                     : (rd_start_reg < key);

    assign wr_en    = cmd.shift_write | cmd.ins_write;
    assign wr_addr  = cmd.shift_write ? j_reg[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
    assign wr_start = cmd.shift_write ? rd_start_reg : item_reg.start_time;
    assign wr_end   = cmd.shift_write ? rd_end_reg   : item_reg.end_time;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            end_mem[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_start_reg <= start_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
    end

    assign gap = {1'b0, rd_start_reg} - {1'b0, item_reg.point};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= req_data;
        if (cmd.res_set)
        begin
            case (cmd.res_sel)
                RES_ZERO:
                begin
                    res_reg.status    <= 1'b0;
                    res_reg.wait_span <= '0;
                end
                RES_FULL:
                begin
                    res_reg.status    <= 1'b1;
                    res_reg.wait_span <= '0;
                end
                RES_NONE:
                begin
                    res_reg.status    <= 1'b0;
                    res_reg.wait_span <= '1;
                end
                RES_GAP:
                begin
                    res_reg.status    <= 1'b0;
                    res_reg.wait_span <= gap;
                end
                default:
                begin
                    res_reg.status    <= 1'b0;
                    res_reg.wait_span <= '0;
                end
            endcase
        end
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.ins_write)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.search_init)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
                j_reg  <= count_reg;
            end
            else if (cmd.search_step)
            begin
                if (go_right)
                    lo_reg <= mid + CNT_W'(1);
                else
                    hi_reg <= mid;
            end

            if (cmd.shift_write)
                j_reg <= j_reg - CNT_W'(1);
        end
    end

    // Hold a result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg & rsp_stall;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign sts.func        = item_reg.func;
    assign sts.full        = (count_reg == CNT_W'(MAX_INTERVALS));
    assign sts.lo_lt_hi    = (lo_reg < hi_reg);
    assign sts.shift_more  = (j_reg > lo_reg);
    assign sts.lo_nonzero  = (lo_reg != '0);
    assign sts.lo_lt_count = (lo_reg < count_reg);
    assign sts.in_prev     = (item_reg.point >= rd_start_reg) && (item_reg.point < rd_end_reg);
    assign sts.out_free    = !out_valid_reg || !rsp_stall;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("entry count above table size");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_shift_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_write |-> (j_reg > lo_reg))
        else $error("shift write at or below insert position");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |-> !sts.full)
        else $error("insert into full table");

endmodule

### hdl/siwl_ctrl.sv
// Controller state machine of the sorted interval wait lookup unit.
// Sequences search, shift, check and result steps; depends on siwl_pkg.
module siwl_ctrl
    import siwl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_DECODE   = 12'b0000_0000_0010,
        ST_SRCH_RD  = 12'b0000_0000_0100,
        ST_SRCH_CMP = 12'b0000_0000_1000,
        ST_SH_RD    = 12'b0000_0001_0000,
        ST_SH_WR    = 12'b0000_0010_0000,
        ST_INS_WR   = 12'b0000_0100_0000,
        ST_PRV_RD   = 12'b0000_1000_0000,
        ST_PRV_CHK  = 12'b0001_0000_0000,
        ST_NXT_RD   = 12'b0010_0000_0000,
        ST_NXT_CHK  = 12'b0100_0000_0000,
        ST_FINISH   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.func)
                    FUNC_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.res_set     = 1'b1;
                        cmd.res_sel     = RES_ZERO;
                        state_next      = ST_FINISH;
                    end
                    FUNC_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_set = 1'b1;
                            cmd.res_sel = RES_FULL;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = ST_SRCH_RD;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SRCH_RD;
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = ST_FINISH;
                    end
                endcase
            end
            ST_SRCH_RD:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = ST_SRCH_CMP;
                end
                else if (sts.func == FUNC_INSERT)
                    state_next = ST_SH_RD;
                else
                    state_next = ST_PRV_RD;
            end
            ST_SRCH_CMP:
            begin
                cmd.search_step = 1'b1;
                state_next      = ST_SRCH_RD;
            end
            ST_SH_RD:
            begin
                // Move entries up one slot, from the top down to the insert position
                if (sts.shift_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SHIFT;
                    state_next = ST_SH_WR;
                end
                else
                    state_next = ST_INS_WR;
            end
            ST_SH_WR:
            begin
                cmd.shift_write = 1'b1;
                state_next      = ST_SH_RD;
            end
            ST_INS_WR:
            begin
                cmd.ins_write = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_sel   = RES_ZERO;
                state_next    = ST_FINISH;
            end
            ST_PRV_RD:
            begin
                if (sts.lo_nonzero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = ST_PRV_CHK;
                end
                else
                    state_next = ST_NXT_RD;
            end
            ST_PRV_CHK:
            begin
                if (sts.in_prev)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    state_next  = ST_FINISH;
                end
                else
                    state_next = ST_NXT_RD;
            end
            ST_NXT_RD:
            begin
                if (sts.lo_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = ST_NXT_CHK;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_NONE;
                    state_next  = ST_FINISH;
                end
            end
            ST_NXT_CHK:
            begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_GAP;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for the output slot to free up
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_DECODE))
        else $error("transfer not followed by decode");

    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending transfer");

endmodule
